[hw/rtl/scalar_kalman_filter_bank_defines.svh]
// Assertion macros for the scalar Kalman filter bank checker.
// No dependencies; included by the checker file.
`ifndef SCALAR_KALMAN_FILTER_BANK_DEFINES_SVH
`define SCALAR_KALMAN_FILTER_BANK_DEFINES_SVH

// Next-cycle implication, disabled while reset is high.
`define SKFB_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define SKFB_ASSERT_RST(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/skfb_pkg.sv]
// Shared types and constants of the scalar Kalman filter bank.
// No dependencies; used by the interfaces and the top level.
package skfb_pkg;

   localparam int CHANNELS  = 9;
   localparam int CHANNEL_W = 4;
   localparam int SAMPLE_W  = 16;
   localparam int DATA_W    = 32;
   localparam int CSR_IDX_W = 2;
   localparam int DIV_STEPS = 31;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   localparam logic [DATA_W-1:0] ONE_Q30  = 32'h4000_0000;
   localparam logic [DATA_W-1:0] HALF_Q30 = 32'h2000_0000;
   localparam logic [DATA_W-1:0] Q_RESET  = 32'd10737;
   localparam logic [DATA_W-1:0] R_RESET  = 32'd53687;

   localparam logic [CSR_IDX_W-1:0] REG_PROCESS_NOISE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MEASUREMENT_NOISE = 2'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIV,
      ST_MUL_X,
      ST_MUL_P,
      ST_DONE
   } skfb_state_type;

endpackage

[hw/rtl/skfb_ifs.sv]
// Handshake interfaces: sample items in, estimate items out, register writes.
// Depends on skfb_pkg.
interface skfb_req_if;
   import skfb_pkg::*;
   logic                        valid;
   logic                        ready;
   logic [CHANNEL_W-1:0]        channel;
   logic signed [SAMPLE_W-1:0]  sample;
   modport source (output valid, channel, sample, input ready);
   modport sink   (input valid, channel, sample, output ready);
endinterface

interface skfb_rsp_if;
   import skfb_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [CHANNEL_W-1:0]      out_channel;
   logic signed [DATA_W-1:0]  estimate;
   modport source (output valid, out_channel, estimate, input ready);
   modport sink   (input valid, out_channel, estimate, output ready);
endinterface

interface skfb_csr_if;
   import skfb_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [DATA_W-1:0]     data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/scalar_kalman_filter_bank.sv]
// Items are handled one at a time: a new item is accepted only when idle, once the previous
// one has run the 31-step restoring gain divider and two passes through the single shared
// multiplier and its result is in the output register (an out-of-range channel skips both).
// Reset (synchronous): estimates to 0, covariances to 1.0, noise registers to
// their defaults; no clearing pass, ready in the cycle after reset.
module scalar_kalman_filter_bank (
   input  logic           clock,
   input  logic           reset,
   skfb_req_if.sink       req_bus,
   skfb_rsp_if.source     rsp_bus,
   skfb_csr_if.sink       csr_bus
);
   import skfb_pkg::*;

   skfb_state_type state_ff, state_in;

   logic [CHANNEL_W-1:0]       ch_ff, ch_in;
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;
   logic [DATA_W-1:0]          x_ff, x_in;
   logic [DATA_W-1:0]          pn_ff, pn_in;
   logic [DATA_W:0]            den_ff, den_in;
   logic                       neg_ff, neg_in;
   logic [DATA_W:0]            mag_ff, mag_in;
   logic [DATA_W+1:0]          rem_ff, rem_in;
   logic [30:0]                k_ff, k_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [63:0]                prod_ff, prod_in;
   logic [DATA_W-1:0]          qn_ff, rn_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [CHANNEL_W-1:0]       rsp_ch_ff, rsp_ch_in;
   logic [DATA_W-1:0]          rsp_est_ff, rsp_est_in;

   logic [DATA_W-1:0] est_ff [CHANNELS];
   logic [DATA_W-1:0] cov_ff [CHANNELS];

   logic              ch_ok;
   logic              wr_en;
   logic [DATA_W-1:0] np;
   logic [DATA_W-1:0] x_sel, p_sel, z;
   logic [DATA_W:0]   psum, d;
   logic [DATA_W+1:0] trial, r_mag, x_ext, nx;
   logic              ge;
   logic [63:0]       rnd;
   logic [30:0]       mul_a;
   logic [DATA_W:0]   mul_b;

   assign ch_ok = ({28'd0, ch_ff} < CHANNELS);
   assign x_sel = ch_ok ? est_ff[ch_ff] : '0;
   assign p_sel = ch_ok ? cov_ff[ch_ff] : '0;
   assign rnd   = prod_ff + {32'd0, HALF_Q30};
   assign np    = rnd[61:30];
   assign prod_in = (state_ff == ST_MUL_X || state_ff == ST_MUL_P)
                    ? ({33'd0, mul_a} * {31'd0, mul_b}) : prod_ff;

   assign req_bus.ready       = (state_ff == ST_IDLE);
   assign csr_bus.ready       = 1'b1;
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.out_channel = rsp_ch_ff;
   assign rsp_bus.estimate    = rsp_est_ff;

   always_comb begin
      state_in     = state_ff;
      ch_in        = ch_ff;
      sample_in    = sample_ff;
      x_in         = x_ff;
      pn_in        = pn_ff;
      den_in       = den_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      rem_in       = rem_ff;
      k_in         = k_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_ch_in    = rsp_ch_ff;
      rsp_est_in   = rsp_est_ff;
      wr_en        = 1'b0;
      mul_a        = k_ff;
      mul_b        = mag_ff;
      psum         = {1'b0, p_sel} + {1'b0, qn_ff};
      z            = {sample_ff, 16'h0000};
      d            = {z[DATA_W-1], z} - {x_sel[DATA_W-1], x_sel};
      trial        = (cnt_ff == '0) ? rem_ff : {rem_ff[DATA_W:0], 1'b0};
      ge           = (den_ff != '0) && (trial >= {1'b0, den_ff});
      r_mag        = rnd[63:30];
      x_ext        = {{2{x_ff[DATA_W-1]}}, x_ff};
      nx           = neg_ff ? (x_ext - r_mag) : (x_ext + r_mag);
      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               ch_in     = req_bus.channel;
               sample_in = req_bus.sample;
               state_in  = ST_LOAD;
            end
         end
         ST_LOAD: begin
            pn_in  = psum[DATA_W] ? '1 : psum[DATA_W-1:0];
            den_in = {1'b0, pn_in} + {1'b0, rn_ff};
            x_in   = x_sel;
            neg_in = d[DATA_W];
            mag_in = d[DATA_W] ? (~d + 1'b1) : d;
            rem_in = {2'b00, pn_in};
            k_in   = '0;
            cnt_in = '0;
            if (ch_ok) begin
               state_in = ST_DIV;
            end else begin
               x_in     = '0;
               state_in = ST_DONE;
            end
         end
         ST_DIV: begin
            rem_in = ge ? (trial - {1'b0, den_ff}) : trial;
            k_in   = {k_ff[29:0], ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_MUL_X;
            end
         end
         ST_MUL_X: begin
            state_in = ST_MUL_P;
         end
         ST_MUL_P: begin
            x_in     = nx[DATA_W-1:0];
            mul_a    = ONE_Q30[30:0] - k_ff;
            mul_b    = {1'b0, pn_ff};
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               wr_en        = ch_ok;
               rsp_valid_in = 1'b1;
               rsp_ch_in    = ch_ff;
               rsp_est_in   = x_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff      <= ch_in;
      sample_ff  <= sample_in;
      x_ff       <= x_in;
      pn_ff      <= pn_in;
      den_ff     <= den_in;
      neg_ff     <= neg_in;
      mag_ff     <= mag_in;
      rem_ff     <= rem_in;
      k_ff       <= k_in;
      cnt_ff     <= cnt_in;
      prod_ff    <= prod_in;
      rsp_ch_ff  <= rsp_ch_in;
      rsp_est_ff <= rsp_est_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qn_ff <= Q_RESET;
         rn_ff <= R_RESET;
      end else if (csr_bus.valid) begin
         if (csr_bus.index == REG_PROCESS_NOISE) begin
            qn_ff <= csr_bus.data;
         end
         if (csr_bus.index == REG_MEASUREMENT_NOISE) begin
            rn_ff <= csr_bus.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            est_ff[i] <= '0;
            cov_ff[i] <= ONE_Q30;
         end
      end else if (wr_en) begin
         est_ff[ch_ff] <= x_ff;
         cov_ff[ch_ff] <= np;
      end
   end

endmodule

[hw/rtl/skfb_checker.sv]
// Port-level checks for scalar_kalman_filter_bank, attached by bind.
// Depends on skfb_pkg and scalar_kalman_filter_bank_defines.svh.
`include "scalar_kalman_filter_bank_defines.svh"

module skfb_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [skfb_pkg::CHANNEL_W-1:0]     rsp_out_channel,
   input logic [skfb_pkg::DATA_W-1:0]        rsp_estimate
);
   import skfb_pkg::*;

   `SKFB_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "ready after accept")
   `SKFB_ASSERT_NEXT(a_no_instant_result, req_valid && req_ready, !$rose(rsp_valid), "early result")
   `SKFB_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_estimate) && $stable(rsp_out_channel), "stalled item changed")
   `SKFB_ASSERT_RST(a_reset_state, reset, !rsp_valid && req_ready, "bad state after reset")

endmodule

bind scalar_kalman_filter_bank skfb_checker u_skfb_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_out_channel (rsp_bus.out_channel),
   .rsp_estimate    (rsp_bus.estimate)
);
